>>> hdl/tgc_pkg.sv
package tgc_pkg;

    // Q10.8 bound width, one sign-extended bit beyond the roll input
    localparam int unsigned BOUND_W = 18;
    localparam int unsigned PITCH_W = 16;
    localparam int unsigned ROLL_W  = 17;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned FRAC_W  = 8;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] CFG_WARMUP = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CALIB  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_FRAC   = 2'd2;

    localparam logic [COUNT_W-1:0] WARMUP_RST = 16'd1000;
    localparam logic [COUNT_W-1:0] CALIB_RST  = 16'd4000;
    localparam logic [FRAC_W-1:0]  FRAC_RST   = 8'd128;

    typedef enum logic [2:0] {
        DIR_STILL = 3'd0,
        DIR_DOWN  = 3'd1,
        DIR_UP    = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } t_dir;

    typedef logic signed [BOUND_W-1:0] t_bound;

    // classification of one sample against the current windows
    typedef struct packed {
        logic hit;
        t_dir dir;
    } t_cls;

endpackage

>>> hdl/tgc_widen.sv
module tgc_widen (
    input  tgc_pkg::t_bound              i_lo,
    input  tgc_pkg::t_bound              i_hi,
    input  logic [tgc_pkg::FRAC_W-1:0]   i_frac,
    output tgc_pkg::t_bound              o_lo,
    output tgc_pkg::t_bound              o_hi
);

    localparam int unsigned BW = tgc_pkg::BOUND_W;
    localparam int unsigned FW = tgc_pkg::FRAC_W;

    logic signed [BW:0]       w_span;
    logic [BW-1:0]            w_span_u;
    logic [BW+FW-1:0]         w_prod;
    logic [BW-1:0]            w_adj;
    logic signed [BW+1:0]     w_lo_x;
    logic signed [BW+1:0]     w_hi_x;

    function automatic tgc_pkg::t_bound sat(input logic signed [BW+1:0] v);
        if (v[BW+1:BW-1] == 3'b000 || v[BW+1:BW-1] == 3'b111) begin
            sat = v[BW-1:0];
        end else if (v[BW+1]) begin
            sat = {1'b1, {(BW-1){1'b0}}};
        end else begin
            sat = {1'b0, {(BW-1){1'b1}}};
        end
    endfunction

    always_comb begin
        w_span   = {i_hi[BW-1], i_hi} - {i_lo[BW-1], i_lo};
        // span is never negative in normal use; clamp anyway
        w_span_u = w_span[BW] ? '0 : w_span[BW-1:0];
        w_prod   = w_span_u * i_frac;
        w_adj    = w_prod[BW+FW-1:FW];
        w_lo_x   = {{2{i_lo[BW-1]}}, i_lo} - {2'b00, w_adj};
        w_hi_x   = {{2{i_hi[BW-1]}}, i_hi} + {2'b00, w_adj};
        o_lo     = sat(w_lo_x);
        o_hi     = sat(w_hi_x);
    end

endmodule

>>> hdl/tgc_classify.sv
module tgc_classify (
    input  tgc_pkg::t_bound i_pitch,
    input  tgc_pkg::t_bound i_roll,
    input  tgc_pkg::t_bound i_pitch_lo,
    input  tgc_pkg::t_bound i_pitch_hi,
    input  tgc_pkg::t_bound i_roll_lo,
    input  tgc_pkg::t_bound i_roll_hi,
    output tgc_pkg::t_cls   o_cls
);

    logic w_p_in;
    logic w_r_in;

    // strict compares: a sample on a bound is outside that axis window
    always_comb begin
        w_p_in = (i_pitch > i_pitch_lo) && (i_pitch < i_pitch_hi);
        w_r_in = (i_roll > i_roll_lo) && (i_roll < i_roll_hi);
        o_cls.hit = 1'b1;
        o_cls.dir = tgc_pkg::DIR_STILL;
        if (w_p_in && w_r_in) begin
            o_cls.dir = tgc_pkg::DIR_STILL;
        end else if (i_pitch > i_pitch_hi && w_r_in) begin
            o_cls.dir = tgc_pkg::DIR_DOWN;
        end else if (i_pitch < i_pitch_lo && w_r_in) begin
            o_cls.dir = tgc_pkg::DIR_UP;
        end else if (i_roll > i_roll_hi && w_p_in) begin
            o_cls.dir = tgc_pkg::DIR_LEFT;
        end else if (i_roll < i_roll_lo && w_p_in) begin
            o_cls.dir = tgc_pkg::DIR_RIGHT;
        end else begin
            o_cls.hit = 1'b0;
        end
    end

endmodule

>>> hdl/tilt_gesture_classifier.sv
// Datapath: an accepted sample passes the input register, then the result register.
// Throughput: 1 beat per cycle when not stalled; the whole per-sample update (window
// compares or one 18x8 widening multiply per axis) sits between the input and result registers.
// Reset (i_rst_n low, synchronous): config back to 1000 / 4000 / 128, sample count,
// bounds, held direction and heading cleared; both pipeline registers emptied.
module tilt_gesture_classifier (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config write port
    input  logic                         i_cfg_we,
    input  logic [tgc_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [tgc_pkg::CFG_W-1:0]    i_cfg_data,
    // sample input
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [15:0]           i_pitch,
    input  logic signed [16:0]           i_roll,
    // result output
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_direction,
    output logic [1:0]                   o_heading,
    output logic                         o_tone_on,
    output logic                         o_calibrating
);

    localparam int unsigned CW = tgc_pkg::COUNT_W;

    // config registers
    logic [CW-1:0]               r_warmup;
    logic [CW-1:0]               r_calib_end;
    logic [tgc_pkg::FRAC_W-1:0]  r_frac;

    // input register
    logic                        r_in_vld;
    logic signed [15:0]          r_pitch;
    logic signed [16:0]          r_roll;

    // block state
    logic [CW-1:0]               r_count;
    tgc_pkg::t_bound             r_p_lo, r_p_hi, r_r_lo, r_r_hi;
    tgc_pkg::t_bound             n_p_lo, n_p_hi, n_r_lo, n_r_hi;
    tgc_pkg::t_dir               r_dir, n_dir;
    logic [1:0]                  r_orient, n_orient;
    logic                        n_tone, n_calib;

    tgc_pkg::t_bound             w_p, w_r;
    tgc_pkg::t_bound             w_wp_lo, w_wp_hi, w_wr_lo, w_wr_hi;
    tgc_pkg::t_cls               w_cls;
    logic                        w_fire;
    logic                        w_track;

    // compute stage moves when the result register is free or draining
    assign w_fire  = r_in_vld && (!o_valid || !i_stall);
    assign o_stall = r_in_vld && !w_fire;

    assign w_p = {{2{r_pitch[15]}}, r_pitch};
    assign w_r = {r_roll[16], r_roll};

    tgc_widen u_widen_p (
        .i_lo   (r_p_lo),
        .i_hi   (r_p_hi),
        .i_frac (r_frac),
        .o_lo   (w_wp_lo),
        .o_hi   (w_wp_hi)
    );

    tgc_widen u_widen_r (
        .i_lo   (r_r_lo),
        .i_hi   (r_r_hi),
        .i_frac (r_frac),
        .o_lo   (w_wr_lo),
        .o_hi   (w_wr_hi)
    );

    tgc_classify u_classify (
        .i_pitch    (w_p),
        .i_roll     (w_r),
        .i_pitch_lo (r_p_lo),
        .i_pitch_hi (r_p_hi),
        .i_roll_lo  (r_r_lo),
        .i_roll_hi  (r_r_hi),
        .o_cls      (w_cls)
    );

    assign w_track = (r_count > r_warmup) && (r_count < r_calib_end);

    // per-sample update; count zero seeds, then tracking, widening, else classify
    always_comb begin
        n_p_lo   = r_p_lo;
        n_p_hi   = r_p_hi;
        n_r_lo   = r_r_lo;
        n_r_hi   = r_r_hi;
        n_dir    = r_dir;
        n_orient = r_orient;
        n_tone   = 1'b0;
        n_calib  = 1'b1;
        if (r_count == '0) begin
            n_p_lo = w_p;
            n_p_hi = w_p;
            n_r_lo = w_r;
            n_r_hi = w_r;
        end else if (w_track) begin
            if (w_p < r_p_lo) begin
                n_p_lo = w_p;
            end else if (w_p > r_p_hi) begin
                n_p_hi = w_p;
            end
            if (w_r < r_r_lo) begin
                n_r_lo = w_r;
            end else if (w_r > r_r_hi) begin
                n_r_hi = w_r;
            end
        end else if (r_count == r_calib_end) begin
            n_p_lo = w_wp_lo;
            n_p_hi = w_wp_hi;
            n_r_lo = w_wr_lo;
            n_r_hi = w_wr_hi;
        end else begin
            n_calib = 1'b0;
            if (w_cls.hit) begin
                n_dir = w_cls.dir;
                case (w_cls.dir)
                    tgc_pkg::DIR_STILL: begin
                        n_tone = 1'b1;
                    end
                    tgc_pkg::DIR_LEFT: begin
                        n_orient = r_orient - 2'd1;
                    end
                    tgc_pkg::DIR_RIGHT: begin
                        n_orient = r_orient + 2'd1;
                    end
                    default: begin
                        n_orient = r_orient;
                    end
                endcase
            end
        end
    end

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup    <= tgc_pkg::WARMUP_RST;
            r_calib_end <= tgc_pkg::CALIB_RST;
            r_frac      <= tgc_pkg::FRAC_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tgc_pkg::CFG_WARMUP: r_warmup    <= i_cfg_data;
                tgc_pkg::CFG_CALIB:  r_calib_end <= i_cfg_data;
                tgc_pkg::CFG_FRAC:   r_frac      <= i_cfg_data[tgc_pkg::FRAC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_pitch <= i_pitch;
            r_roll  <= i_roll;
        end
    end

    // state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_p_lo   <= '0;
            r_p_hi   <= '0;
            r_r_lo   <= '0;
            r_r_hi   <= '0;
            r_dir    <= tgc_pkg::DIR_STILL;
            r_orient <= '0;
        end else if (w_fire) begin
            if (r_count != '1) begin
                r_count <= r_count + 1'b1;
            end
            r_p_lo   <= n_p_lo;
            r_p_hi   <= n_p_hi;
            r_r_lo   <= n_r_lo;
            r_r_hi   <= n_r_hi;
            r_dir    <= n_dir;
            r_orient <= n_orient;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_fire) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_direction   <= n_dir;
            o_heading     <= n_orient;
            o_tone_on     <= n_tone;
            o_calibrating <= n_calib;
        end
    end

endmodule
